### src/rlp_pkg.sv
// Shared types and constants for the receive-line RSSI/SNR parser.
// Used by rlp_line_parser and rcv_line_rssi_snr_parser; no dependencies.
package rlp_pkg;

    // Parser phase: five prefix characters, three skipped fields, then numbers
    typedef enum logic [3:0] {
        PH_PFX0      = 4'd0,
        PH_PFX1      = 4'd1,
        PH_PFX2      = 4'd2,
        PH_PFX3      = 4'd3,
        PH_PFX4      = 4'd4,
        PH_ADDR      = 4'd5,
        PH_LENF      = 4'd6,
        PH_DATA      = 4'd7,
        PH_RSSI_SIGN = 4'd8,
        PH_RSSI_DIG  = 4'd9,
        PH_SNR_SIGN  = 4'd10,
        PH_SNR_DIG   = 4'd11,
        PH_SNR_FRAC  = 4'd12,
        PH_DONE      = 4'd13,
        PH_FAIL      = 4'd14
    } rlp_phase_t;

    // Event codes reported on each line end or overrun
    typedef enum logic [1:0] {
        EV_PACKET    = 2'd0,
        EV_NO_PACKET = 2'd1,
        EV_OVERRUN   = 2'd2
    } rlp_kind_t;

    // One result request
    typedef struct packed {
        logic [31:0] packet_count;
        logic [15:0] snr_tenths;
        logic [15:0] rssi_dbm;
        rlp_kind_t   event_kind;
    } rlp_result_t;

    // Field limits
    localparam int ADDR_MAX        = 8;
    localparam int LEN_MAX         = 4;
    localparam int RSSI_DIGITS_MAX = 6;
    localparam int SNR_DIGITS_MAX  = 4;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_V     = 8'h56;

endpackage

### src/rlp_line_parser.sv
// Per-byte parse state and the combinational step for one received byte.
// Depends on rlp_pkg; instantiated by rcv_line_rssi_snr_parser.
module rlp_line_parser #(
    parameter int LINE_BUFFER_BYTES = 256,
    parameter int DATA_FIELD_MAX    = 100
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,      // byte is consumed this cycle
    input  logic [7:0]          rx_byte,
    output logic                evt,       // this byte produces a result
    output rlp_pkg::rlp_result_t res
);
    import rlp_pkg::*;

    localparam int BUDGET_MAX = (DATA_FIELD_MAX > ADDR_MAX) ? DATA_FIELD_MAX : ADDR_MAX;
    localparam int BUDGET_W   = $clog2(BUDGET_MAX + 1);
    localparam int LEN_W      = $clog2(LINE_BUFFER_BYTES);
    localparam logic [LEN_W-1:0] LINE_LAST = LEN_W'(LINE_BUFFER_BYTES - 1);

    rlp_phase_t          phase_reg, phase_next;
    logic [LEN_W-1:0]    line_length_reg, line_length_next;
    logic [BUDGET_W-1:0] budget_reg, budget_next;
    logic [19:0]         rssi_accum_reg, rssi_accum_next;
    logic                rssi_sign_reg, rssi_sign_next;
    logic [13:0]         snr_whole_reg, snr_whole_next;
    logic [3:0]          snr_tenth_reg, snr_tenth_next;
    logic                snr_neg_reg, snr_neg_next;
    logic [31:0]         packets_reg, packets_next;

    logic                is_cr, is_lf, is_digit, line_full, line_ok, restart;
    logic [3:0]          digit;
    logic [BUDGET_W-1:0] field_cap, eff_budget;
    rlp_phase_t          skip_dest;
    logic [17:0]         snr_sum;
    logic [15:0]         rssi_out, snr_out;

    // Byte classification and result fields
    always_comb begin
        is_cr     = (rx_byte == CH_CR);
        is_lf     = (rx_byte == CH_LF);
        is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
        digit     = rx_byte[3:0];
        line_full = (line_length_reg == LINE_LAST);
        line_ok   = (phase_reg >= PH_SNR_SIGN) && (phase_reg <= PH_DONE);
        snr_sum   = ({4'd0, snr_whole_reg} << 3) + ({4'd0, snr_whole_reg} << 1)
                  + 18'(snr_tenth_reg);
        rssi_out  = rssi_sign_reg ? (16'd0 - rssi_accum_reg[15:0]) : rssi_accum_reg[15:0];
        snr_out   = snr_neg_reg ? (16'd0 - snr_sum[15:0]) : snr_sum[15:0];
        restart   = is_lf || (!is_cr && line_full);

        evt              = restart;
        res.event_kind   = EV_OVERRUN;
        res.rssi_dbm     = 16'd0;
        res.snr_tenths   = 16'd0;
        res.packet_count = packets_reg;
        if (is_lf) begin
            if (line_ok) begin
                res.event_kind   = EV_PACKET;
                res.rssi_dbm     = rssi_out;
                res.snr_tenths   = snr_out;
                res.packet_count = packets_reg + 32'd1;
            end else begin
                res.event_kind   = EV_NO_PACKET;
            end
        end
    end

    // Limit and successor for the three skipped fields
    always_comb begin
        case (phase_reg)
            PH_ADDR: begin
                field_cap = BUDGET_W'(ADDR_MAX);
                skip_dest = PH_LENF;
            end
            PH_LENF: begin
                field_cap = BUDGET_W'(LEN_MAX);
                skip_dest = PH_DATA;
            end
            default: begin
                field_cap = BUDGET_W'(DATA_FIELD_MAX);
                skip_dest = PH_RSSI_SIGN;
            end
        endcase
        // sign phases start a digit run with an empty budget
        eff_budget = (phase_reg == PH_RSSI_SIGN || phase_reg == PH_SNR_SIGN)
                   ? '0 : budget_reg;
    end

    // Next state
    always_comb begin
        phase_next       = phase_reg;
        line_length_next = line_length_reg;
        budget_next      = budget_reg;
        rssi_accum_next  = rssi_accum_reg;
        rssi_sign_next   = rssi_sign_reg;
        snr_whole_next   = snr_whole_reg;
        snr_tenth_next   = snr_tenth_reg;
        snr_neg_next     = snr_neg_reg;
        packets_next     = packets_reg;

        if (step && restart) begin
            phase_next       = PH_PFX0;
            line_length_next = '0;
            budget_next      = '0;
            rssi_accum_next  = '0;
            rssi_sign_next   = 1'b0;
            snr_whole_next   = '0;
            snr_tenth_next   = '0;
            snr_neg_next     = 1'b0;
            packets_next     = res.packet_count;
        end else if (step && !is_cr) begin
            line_length_next = line_length_reg + LEN_W'(1);
            case (phase_reg)
                PH_PFX0: phase_next = (rx_byte == CH_PLUS) ? PH_PFX1 : PH_FAIL;
                PH_PFX1: phase_next = (rx_byte == CH_R)    ? PH_PFX2 : PH_FAIL;
                PH_PFX2: phase_next = (rx_byte == CH_C)    ? PH_PFX3 : PH_FAIL;
                PH_PFX3: phase_next = (rx_byte == CH_V)    ? PH_PFX4 : PH_FAIL;
                PH_PFX4: phase_next = (rx_byte == CH_EQ)   ? PH_ADDR : PH_FAIL;
                PH_ADDR, PH_LENF, PH_DATA: begin
                    if (rx_byte == CH_COMMA) begin
                        phase_next  = skip_dest;
                        budget_next = '0;
                    end else if (rx_byte != CH_NUL && budget_reg < field_cap) begin
                        budget_next = budget_reg + BUDGET_W'(1);
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_RSSI_SIGN, PH_RSSI_DIG: begin
                    budget_next = eff_budget;
                    if (phase_reg == PH_RSSI_SIGN && rx_byte == CH_MINUS) begin
                        rssi_sign_next = 1'b1;
                        phase_next     = PH_RSSI_DIG;
                    end else if (is_digit && eff_budget < BUDGET_W'(RSSI_DIGITS_MAX)) begin
                        rssi_accum_next = (rssi_accum_reg << 3) + (rssi_accum_reg << 1)
                                        + 20'(digit);
                        budget_next     = eff_budget + BUDGET_W'(1);
                        phase_next      = PH_RSSI_DIG;
                    end else if (rx_byte == CH_COMMA) begin
                        phase_next  = PH_SNR_SIGN;
                        budget_next = '0;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_SNR_SIGN, PH_SNR_DIG: begin
                    budget_next = eff_budget;
                    if (phase_reg == PH_SNR_SIGN && rx_byte == CH_MINUS) begin
                        snr_neg_next = 1'b1;
                        phase_next   = PH_SNR_DIG;
                    end else if (is_digit && eff_budget < BUDGET_W'(SNR_DIGITS_MAX)) begin
                        snr_whole_next = (snr_whole_reg << 3) + (snr_whole_reg << 1)
                                       + 14'(digit);
                        budget_next    = eff_budget + BUDGET_W'(1);
                        phase_next     = PH_SNR_DIG;
                    end else if (rx_byte == CH_DOT) begin
                        phase_next = PH_SNR_FRAC;
                    end else begin
                        phase_next = PH_DONE;
                    end
                end
                PH_SNR_FRAC: begin
                    if (is_digit) begin
                        snr_tenth_next = digit;
                    end
                    phase_next = PH_DONE;
                end
                default: phase_next = phase_reg;  // done and fail hold to line end
            endcase
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_PFX0;
            line_length_reg <= '0;
            budget_reg      <= '0;
            rssi_accum_reg  <= '0;
            rssi_sign_reg   <= 1'b0;
            snr_whole_reg   <= '0;
            snr_tenth_reg   <= '0;
            snr_neg_reg     <= 1'b0;
            packets_reg     <= '0;
        end else begin
            phase_reg       <= phase_next;
            line_length_reg <= line_length_next;
            budget_reg      <= budget_next;
            rssi_accum_reg  <= rssi_accum_next;
            rssi_sign_reg   <= rssi_sign_next;
            snr_whole_reg   <= snr_whole_next;
            snr_tenth_reg   <= snr_tenth_next;
            snr_neg_reg     <= snr_neg_next;
            packets_reg     <= packets_next;
        end
    end

    // Checks
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        line_length_reg <= LINE_LAST)
        else $error("line length beyond buffer");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step && evt && res.event_kind == EV_PACKET |=> packets_reg == $past(packets_reg) + 32'd1)
        else $error("packet count did not advance");
    a_hold_no_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> phase_reg == $past(phase_reg) && packets_reg == $past(packets_reg))
        else $error("state moved without a byte");
    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        step && evt |=> phase_reg == PH_PFX0 && line_length_reg == '0)
        else $error("line not restarted after event");

endmodule

### src/rcv_line_rssi_snr_parser.sv
// Top level of the receive-line RSSI/SNR parser: input register, parser core
// and result register. Depends on rlp_pkg and rlp_line_parser.
//
// Usage:
//   s_ channel: one received byte per request, s_tdata[7:0].
//   m_ channel: one result request per line end or buffer overrun.
//   Carriage returns are dropped. Each newline gives a result of kind packet
//   (with RSSI, SNR times ten and the updated packet count) or kind no-packet;
//   a byte arriving when the line already holds LINE_BUFFER_BYTES-1 bytes is
//   dropped and gives kind overrun, and the line restarts empty.
// Path: a byte taken into the input register passes through the parser core;
//   any result it gives is loaded into the result register, which drives m_tvalid.
// Throughput: one byte per cycle unless stalled; each byte's update is one
//   pass through the parser core between the input and result registers.
// Reset: aresetn low clears the parse state, the packet count and both
//   valid flags.
// Stall: while m_tvalid is high and m_tready low, bytes that give no result
//   still flow; a byte that would give a result waits in the input register
//   and s_tready drops until the result register is freed.
module rcv_line_rssi_snr_parser #(
    parameter int LINE_BUFFER_BYTES = 256,
    parameter int DATA_FIELD_MAX    = 100
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [1:0] event_kind, [17:2] rssi_dbm,
                                   // [33:18] snr_tenths, [65:34] packet_count
);
    import rlp_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        m_valid_reg;
    rlp_result_t res_reg;

    logic        evt, out_free, advance;
    rlp_result_t res;

    // Handshake
    assign out_free = !m_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!evt || out_free);
    assign s_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            byte_reg <= s_tdata;
        end
    end

    // Parser core
    rlp_line_parser #(
        .LINE_BUFFER_BYTES (LINE_BUFFER_BYTES),
        .DATA_FIELD_MAX    (DATA_FIELD_MAX)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (byte_reg),
        .evt     (evt),
        .res     (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && evt) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && evt) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_reg.packet_count, res_reg.snr_tenths,
                       res_reg.rssi_dbm, res_reg.event_kind};

    // Checks
    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && evt |=> m_valid_reg)
        else $error("result not presented");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !(advance && evt))
        else $error("pending result overwritten");
    a_byte_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && byte_reg == $past(byte_reg))
        else $error("waiting byte lost");
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.event_kind != EV_PACKET
        |-> res_reg.rssi_dbm == 16'd0 && res_reg.snr_tenths == 16'd0)
        else $error("nonzero fields on non-packet event");

endmodule
